@@ rtl/core/mqf_pkg.sv @@
// Package for the multi-queue message FIFO: field widths, operation and
// status codes, controller state type and default parameter values.
// No dependencies.
package mqf_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int STORE_DEPTH_DEF = 256;
    localparam int MSG_WIDTH_DEF   = 32;

    localparam int OP_W     = 2;
    localparam int QID_W    = 4;
    localparam int DATA_W   = 32;
    localparam int BYTES_W  = 8;
    localparam int STATUS_W = 3;
    localparam int NEWQ_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_SEND    = 2'd2,
        OP_RECEIVE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BAD_ID   = 3'd1,
        STAT_BAD_SIZE = 3'd2,
        STAT_NO_QUEUE = 3'd3,
        STAT_EMPTY    = 3'd4,
        STAT_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

endpackage

@@ rtl/core/mqf_if.sv @@
// Valid/ready channel interfaces for the operation requests and the results.
// Depends on mqf_pkg for the field widths.
interface mqf_in_if import mqf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [QID_W-1:0]   queue_id;
    logic [DATA_W-1:0]  msg_data;
    logic [BYTES_W-1:0] msg_bytes;

    modport source (output valid, output op, output queue_id, output msg_data,
                    output msg_bytes, input ready);
    modport sink   (input valid, input op, input queue_id, input msg_data,
                    input msg_bytes, output ready);
endinterface

interface mqf_out_if import mqf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NEWQ_W-1:0]   new_queue;
    logic [DATA_W-1:0]   recv_data;
    logic [BYTES_W-1:0]  recv_bytes;

    modport source (output valid, output status, output new_queue, output recv_data,
                    output recv_bytes, input ready);
    modport sink   (input valid, input status, input new_queue, input recv_data,
                    input recv_bytes, output ready);
endinterface

@@ rtl/core/mqf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/multi_queue_message_fifo_unit.sv @@
// Multi-queue message FIFO: queue tables in flip-flops, slot words and links in two RAMs.
// The request transfer moves the controller to the execute state, where the slot RAM read
// data arrives; the result register is loaded when the execute state commits.
// A new request is taken only in the idle state, once the previous result has been loaded,
// as the slot RAM read precedes each read-modify-write; a stalled result holds the execute state.
// Reset (synchronous, active low) clears the queue tables at once; no clearing pass runs,
// the initial free-list links come from a high-water mark. Depends on mqf_pkg, mqf_if, mqf_ram.
module multi_queue_message_fifo_unit import mqf_pkg::*; #(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MSG_WIDTH   = MSG_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mqf_in_if.sink    i_in,
    mqf_out_if.source o_out
);

    // Queue index, slot pointer and slot count widths.
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Controller state and the captured request.
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [OP_W-1:0]      r_op;
    logic [QID_W-1:0]     r_qid;
    logic [MSG_WIDTH-1:0] r_word;
    logic [BYTES_W-1:0]   r_bytes;
    logic [AW-1:0]        r_rd_addr;

    // ------------------------------------------------------------------
    // Queue tables. A size of zero marks an unused queue.
    // ------------------------------------------------------------------
    logic [BYTES_W-1:0] r_size     [NUM_QUEUES];
    logic [BYTES_W-1:0] n_size     [NUM_QUEUES];
    logic [AW-1:0]      r_head     [NUM_QUEUES];
    logic [AW-1:0]      n_head     [NUM_QUEUES];
    logic [AW-1:0]      r_tail     [NUM_QUEUES];
    logic [AW-1:0]      n_tail     [NUM_QUEUES];
    logic [CW-1:0]      r_count    [NUM_QUEUES];
    logic [CW-1:0]      n_count    [NUM_QUEUES];
    logic               r_nonempty [NUM_QUEUES];
    logic               n_nonempty [NUM_QUEUES];

    // Free list head, free slot count and the high-water mark. Every slot at or
    // above the mark has never been handed out, so its link is still the
    // initial one (the next slot, wrapping to zero at the end of the store).
    logic [AW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_free_count, n_free_count;
    logic [CW-1:0] r_hw, n_hw;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [NEWQ_W-1:0]   r_new_queue, n_new_queue;
    logic [DATA_W-1:0]   r_recv_data, n_recv_data;
    logic [BYTES_W-1:0]  r_recv_bytes, n_recv_bytes;

    // ------------------------------------------------------------------
    // Slot RAMs: one holds the message words, the other the links.
    // ------------------------------------------------------------------
    logic                 w_data_we;
    logic [AW-1:0]        w_data_waddr;
    logic [MSG_WIDTH-1:0] w_data_q;
    logic                 w_next_we;
    logic [AW-1:0]        w_next_waddr;
    logic [AW-1:0]        w_next_wdata;
    logic [AW-1:0]        w_next_q;

    logic          w_accept;
    logic          w_commit;
    logic [QW-1:0] w_a_qi;
    logic          w_a_qok;
    logic [AW-1:0] w_a_head;
    logic [AW-1:0] w_a_raddr;

    // The request transfer happens only in the idle state; the reads it starts
    // deliver their data during the execute cycle.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_a_qi    = i_in.queue_id[QW-1:0];
    assign w_a_qok   = ({1'b0, i_in.queue_id} < (QID_W + 1)'(NUM_QUEUES));
    assign w_a_head  = w_a_qok ? r_head[w_a_qi] : '0;
    // A send follows the free list; a receive follows the queue's head.
    assign w_a_raddr = (t_op'(i_in.op) == OP_SEND) ? r_free_head : w_a_head;

    mqf_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (w_data_waddr),
        .i_wdata (r_word),
        .i_re    (w_accept),
        .i_raddr (w_a_raddr),
        .o_rdata (w_data_q)
    );

    mqf_ram #(
        .WIDTH (AW),
        .DEPTH (STORE_DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_re    (w_accept),
        .i_raddr (w_a_raddr),
        .o_rdata (w_next_q)
    );

    // ------------------------------------------------------------------
    // Execute cycle. The updates and RAM writes commit together with the
    // result, so a result that cannot yet be moved into the output register
    // simply holds everything, the RAM read data included.
    // ------------------------------------------------------------------
    logic [QW-1:0]      w_qi;
    logic               w_bad_id;
    logic [BYTES_W-1:0] w_q_size;
    logic [AW-1:0]      w_q_head;
    logic [AW-1:0]      w_q_tail;
    logic [CW-1:0]      w_q_count;
    logic               w_q_nonempty;
    logic [AW-1:0]      w_rd_next;
    logic               w_free_found;
    logic [QID_W-1:0]   w_free_idx;
    logic [63:0]        w_wide_data;

    assign w_commit = (r_state == ST_EXEC) && (!r_out_valid || o_out.ready);

    assign w_qi         = r_qid[QW-1:0];
    assign w_bad_id     = ({1'b0, r_qid} >= (QID_W + 1)'(NUM_QUEUES));
    assign w_q_size     = w_bad_id ? '0 : r_size[w_qi];
    assign w_q_head     = w_bad_id ? '0 : r_head[w_qi];
    assign w_q_tail     = w_bad_id ? '0 : r_tail[w_qi];
    assign w_q_count    = w_bad_id ? '0 : r_count[w_qi];
    assign w_q_nonempty = w_bad_id ? 1'b0 : r_nonempty[w_qi];
    assign w_wide_data  = 64'(w_data_q);

    // Link of the slot that was read: from the RAM once the slot has been used,
    // otherwise the initial chaining.
    always_comb begin
        if ({1'b0, r_rd_addr} >= r_hw) begin
            w_rd_next = (r_rd_addr == AW'(STORE_DEPTH - 1)) ? '0 : r_rd_addr + 1'b1;
        end else begin
            w_rd_next = w_next_q;
        end
    end

    // Lowest unused queue for a create.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
            if (r_size[i] == '0) begin
                w_free_found = 1'b1;
                w_free_idx   = QID_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_nonempty   = r_nonempty;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_hw         = r_hw;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_status     = r_status;
        n_new_queue  = r_new_queue;
        n_recv_data  = r_recv_data;
        n_recv_bytes = r_recv_bytes;
        w_data_we    = 1'b0;
        w_data_waddr = r_free_head;
        w_next_we    = 1'b0;
        w_next_waddr = w_q_tail;
        w_next_wdata = r_free_head;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_commit) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_status     = STAT_OK;
                    n_new_queue  = '0;
                    n_recv_data  = '0;
                    n_recv_bytes = '0;
                    if (t_op'(r_op) == OP_CREATE) begin
                        if (r_bytes == '0) begin
                            n_status = STAT_BAD_SIZE;
                        end else if (!w_free_found) begin
                            n_status = STAT_NO_QUEUE;
                        end else begin
                            n_size[w_free_idx[QW-1:0]]     = r_bytes;
                            n_nonempty[w_free_idx[QW-1:0]] = 1'b0;
                            n_count[w_free_idx[QW-1:0]]    = '0;
                            n_new_queue                    = w_free_idx[NEWQ_W-1:0];
                        end
                    end else if (w_bad_id) begin
                        n_status = STAT_BAD_ID;
                    end else if (t_op'(r_op) == OP_DESTROY) begin
                        // Destroying an unused queue is accepted and changes nothing.
                        if (w_q_size != '0) begin
                            if (w_q_nonempty) begin
                                // Splice the whole chain in front of the free list.
                                w_next_we    = 1'b1;
                                w_next_waddr = w_q_tail;
                                w_next_wdata = r_free_head;
                                n_free_head  = w_q_head;
                                n_free_count = r_free_count + w_q_count;
                            end
                            n_size[w_qi]     = '0;
                            n_head[w_qi]     = '0;
                            n_tail[w_qi]     = '0;
                            n_nonempty[w_qi] = 1'b0;
                            n_count[w_qi]    = '0;
                        end
                    end else if (w_q_size == '0) begin
                        n_status = STAT_BAD_ID;
                    end else if (t_op'(r_op) == OP_SEND) begin
                        if (r_free_count == '0) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_data_we    = 1'b1;
                            w_data_waddr = r_free_head;
                            n_free_head  = w_rd_next;
                            n_free_count = r_free_count - 1'b1;
                            if ({1'b0, r_free_head} >= r_hw) begin
                                n_hw = r_hw + 1'b1;
                            end
                            if (w_q_nonempty) begin
                                w_next_we    = 1'b1;
                                w_next_waddr = w_q_tail;
                                w_next_wdata = r_free_head;
                            end else begin
                                n_head[w_qi] = r_free_head;
                            end
                            n_tail[w_qi]     = r_free_head;
                            n_nonempty[w_qi] = 1'b1;
                            n_count[w_qi]    = w_q_count + 1'b1;
                        end
                    end else begin
                        if (!w_q_nonempty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_recv_data  = w_wide_data[DATA_W-1:0];
                            n_recv_bytes = w_q_size;
                            n_count[w_qi] = w_q_count - 1'b1;
                            if (w_q_count == CW'(1)) begin
                                n_nonempty[w_qi] = 1'b0;
                            end else begin
                                n_head[w_qi] = w_rd_next;
                            end
                            // The popped slot goes back to the front of the free list.
                            w_next_we    = 1'b1;
                            w_next_waddr = w_q_head;
                            w_next_wdata = r_free_head;
                            n_free_head  = w_q_head;
                            n_free_count = r_free_count + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_free_head  <= '0;
            r_free_count <= CW'(STORE_DEPTH);
            r_hw         <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_size[i]     <= '0;
                r_head[i]     <= '0;
                r_tail[i]     <= '0;
                r_count[i]    <= '0;
                r_nonempty[i] <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_hw         <= n_hw;
            r_size       <= n_size;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_nonempty   <= n_nonempty;
        end
    end

    // Request capture and result payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_in.op;
            r_qid     <= i_in.queue_id;
            r_word    <= MSG_WIDTH'(i_in.msg_data);
            r_bytes   <= i_in.msg_bytes;
            r_rd_addr <= w_a_raddr;
        end
        r_status     <= n_status;
        r_new_queue  <= n_new_queue;
        r_recv_data  <= n_recv_data;
        r_recv_bytes <= n_recv_bytes;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.new_queue  = r_new_queue;
    assign o_out.recv_data  = r_recv_data;
    assign o_out.recv_bytes = r_recv_bytes;

endmodule
